### src/dnsx_pkg.sv
`default_nettype none
package dnsx_pkg;
    localparam int MsgDepth = 4096;
    localparam int AddrW = $clog2(MsgDepth);
    localparam int CntW = AddrW + 1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_TRUNC = 2'd1;
    localparam logic [1:0] ST_MAL = 2'd2;
    localparam logic [1:0] ST_LONG = 2'd3;

    localparam logic [7:0] PtrMask = 8'hc0;
    localparam logic [7:0] OffMask = 8'h3f;
    localparam logic [15:0] QrBit = 16'h8000;
    localparam logic [15:0] OpMask = 16'h7800;
    localparam logic [15:0] ZBit = 16'h0040;
    localparam logic [15:0] TcBit = 16'h0200;
    localparam logic [15:0] RcMask = 16'h000f;
    localparam logic [7:0] MaxHops = 8'd128;
    localparam logic [8:0] MaxWire = 9'd254;
    localparam logic [CntW-1:0] HdrLen = CntW'(12);
    localparam logic [CntW-1:0] RrFixed = CntW'(10);

    typedef struct packed {
        logic [1:0] status;
        logic [31:0] address;
        logic [31:0] ttl;
    } result_t;
endpackage
`default_nettype wire

### src/dns_first_a_record_extractor.sv
`default_nettype none
// Bytes of a DNS response are taken one per cycle into a 4096-byte store. After the
// byte marked last the block stops taking bytes and parses the message with a
// single byte-wide read port and a small sequencer, sweeping the whole visited
// bitmap clear before every question or answer name that it walks. One result
// (status, address, TTL) is given per message and held in an output register until
// taken; the next message is taken only after that.
module dns_first_a_record_extractor (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic last_byte,
    output logic out_valid,
    input  wire logic out_ready,
    output logic [1:0] status,
    output logic [31:0] address,
    output logic [31:0] ttl
);
    localparam int AW = dnsx_pkg::AddrW;
    localparam int CW = dnsx_pkg::CntW;

    logic [CW-1:0] count_reg;
    logic ovf_reg, busy_reg, out_valid_reg;
    logic accept, start, done, room;
    logic [AW-1:0] p_addr;
    logic [7:0] rd_data;
    dnsx_pkg::result_t res, out_reg;

    assign in_ready = !busy_reg;
    assign accept = in_valid && in_ready;
    assign room = count_reg < CW'(dnsx_pkg::MsgDepth);
    assign start = accept && last_byte;

    dnsx_store u_store (
        .clk(clk), .wr_en(accept && room), .wr_addr(count_reg[AW-1:0]),
        .wr_data(data_byte), .rd_addr(p_addr), .rd_data(rd_data)
    );

    dnsx_parser u_parser (
        .clk(clk), .rst_n(rst_n), .start(busy_reg && !out_valid_reg && !done),
        .len(count_reg), .overflow(ovf_reg), .rd_addr(p_addr), .rd_data(rd_data),
        .done(done), .result(res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg <= 1'b0;
            busy_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (room)
                begin
                    count_reg <= count_reg + CW'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
                if (start)
                begin
                    busy_reg <= 1'b1;
                end
            end
            if (done)
            begin
                out_reg <= res;
                out_valid_reg <= 1'b1;
                count_reg <= '0;
                ovf_reg <= 1'b0;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
                busy_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign status = out_reg.status;
    assign address = out_reg.address;
    assign ttl = out_reg.ttl;
endmodule
`default_nettype wire

### src/dnsx_store.sv
`default_nettype none
module dnsx_store (
    input  wire logic clk,
    input  wire logic wr_en,
    input  wire logic [dnsx_pkg::AddrW-1:0] wr_addr,
    input  wire logic [7:0] wr_data,
    input  wire logic [dnsx_pkg::AddrW-1:0] rd_addr,
    output logic [7:0] rd_data
);
    logic [7:0] mem [dnsx_pkg::MsgDepth];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

### src/dnsx_visited.sv
`default_nettype none
// visited bitmap with one write and one registered read, cleared by a sweep
module dnsx_visited (
    input  wire logic clk,
    input  wire logic wr_en,
    input  wire logic [dnsx_pkg::AddrW-1:0] wr_addr,
    input  wire logic wr_bit,
    input  wire logic [dnsx_pkg::AddrW-1:0] rd_addr,
    output logic rd_bit
);
    logic mem [dnsx_pkg::MsgDepth];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_bit;
        end
        rd_bit <= mem[rd_addr];
    end
endmodule
`default_nettype wire

### src/dnsx_parser.sv
`default_nettype none
module dnsx_parser (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic [dnsx_pkg::CntW-1:0] len,
    input  wire logic overflow,
    output logic [dnsx_pkg::AddrW-1:0] rd_addr,
    input  wire logic [7:0] rd_data,
    output logic done,
    output dnsx_pkg::result_t result
);
    localparam int AW = dnsx_pkg::AddrW;
    localparam int CW = dnsx_pkg::CntW;

    typedef enum logic [4:0] {
        S_IDLE, S_HDR_RD, S_HDR_WT, S_HDR_CHK,
        S_SEC, S_CLR, S_NB_RD, S_NB_WT, S_NB_EVAL,
        S_P2_WT, S_P2_EVAL, S_V_WT, S_V_EVAL,
        S_FIX, S_FX_RD, S_FX_WT, S_FX_EVAL, S_FX_AFTER,
        S_DONE
    } state_t;

    state_t state_reg;
    logic [CW-1:0] pos_reg, next_reg, cur_reg, rd_cnt_reg;
    logic [CW-1:0] clr_reg;
    logic [15:0] flags_reg, qd_reg, an_reg;
    logic [31:0] acc_reg, ttl_reg, type_cls_reg;
    logic [15:0] dlen_reg;
    logic [3:0] fx_idx_reg;
    logic [7:0] hops_reg;
    logic [8:0] wire_reg;
    logic jumped_reg, in_answer_reg;
    logic [7:0] b_reg;
    logic [AW-1:0] tgt_reg;
    logic [1:0] st_reg;
    logic [31:0] addr_reg, ttlo_reg;
    logic done_reg;
    logic [AW-1:0] raddr_reg;
    logic v_we;
    logic [AW-1:0] v_waddr, v_raddr;
    logic v_wbit, v_rbit;
    logic [CW-1:0] remain;
    logic [13:0] tgt_full;

    assign remain = len - pos_reg;
    assign tgt_full = {b_reg[5:0] & dnsx_pkg::OffMask[5:0], rd_data};

    always_comb
    begin
        v_we = 1'b0;
        v_waddr = clr_reg[AW-1:0];
        v_wbit = 1'b0;
        if (state_reg == S_CLR)
        begin
            v_we = 1'b1;
        end
        else if (state_reg == S_V_EVAL && !v_rbit)
        begin
            v_we = 1'b1;
            v_waddr = tgt_reg;
            v_wbit = 1'b1;
        end
    end
    assign v_raddr = tgt_reg;

    dnsx_visited u_visited (
        .clk(clk), .wr_en(v_we), .wr_addr(v_waddr), .wr_bit(v_wbit),
        .rd_addr(v_raddr), .rd_bit(v_rbit)
    );

    assign rd_addr = raddr_reg;
    assign done = done_reg;
    assign result.status = st_reg;
    assign result.address = addr_reg;
    assign result.ttl = ttlo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        addr_reg <= '0;
                        ttlo_reg <= '0;
                        if (overflow)
                        begin
                            st_reg <= dnsx_pkg::ST_LONG;
                            state_reg <= S_DONE;
                        end
                        else if (len < dnsx_pkg::HdrLen)
                        begin
                            st_reg <= dnsx_pkg::ST_TRUNC;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            rd_cnt_reg <= CW'(2);
                            raddr_reg <= AW'(2);
                            state_reg <= S_HDR_RD;
                        end
                    end
                end
                S_HDR_RD: state_reg <= S_HDR_WT;
                S_HDR_WT:
                begin
                    acc_reg <= {acc_reg[23:0], rd_data};
                    if (rd_cnt_reg == CW'(3)) flags_reg <= {acc_reg[7:0], rd_data};
                    if (rd_cnt_reg == CW'(5)) qd_reg <= {acc_reg[7:0], rd_data};
                    if (rd_cnt_reg == CW'(7)) an_reg <= {acc_reg[7:0], rd_data};
                    if (rd_cnt_reg == CW'(7))
                    begin
                        state_reg <= S_HDR_CHK;
                    end
                    else
                    begin
                        rd_cnt_reg <= rd_cnt_reg + CW'(1);
                        raddr_reg <= rd_cnt_reg[AW-1:0] + AW'(1);
                        state_reg <= S_HDR_RD;
                    end
                end
                S_HDR_CHK:
                begin
                    cur_reg <= dnsx_pkg::HdrLen;
                    in_answer_reg <= 1'b0;
                    if ((flags_reg & dnsx_pkg::QrBit) == '0
                        || (flags_reg & dnsx_pkg::OpMask) != '0
                        || (flags_reg & dnsx_pkg::ZBit) != '0)
                    begin
                        st_reg <= dnsx_pkg::ST_MAL;
                        state_reg <= S_DONE;
                    end
                    else if ((flags_reg & dnsx_pkg::TcBit) != '0)
                    begin
                        st_reg <= dnsx_pkg::ST_TRUNC;
                        state_reg <= S_DONE;
                    end
                    else if ((flags_reg & dnsx_pkg::RcMask) != '0)
                    begin
                        st_reg <= dnsx_pkg::ST_MAL;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_SEC;
                    end
                end
                S_SEC:
                begin
                    if (!in_answer_reg && qd_reg != '0)
                    begin
                        qd_reg <= qd_reg - 16'd1;
                        clr_reg <= '0;
                        state_reg <= S_CLR;
                    end
                    else if (an_reg != '0)
                    begin
                        in_answer_reg <= 1'b1;
                        an_reg <= an_reg - 16'd1;
                        clr_reg <= '0;
                        state_reg <= S_CLR;
                    end
                    else
                    begin
                        st_reg <= dnsx_pkg::ST_MAL;
                        state_reg <= S_DONE;
                    end
                end
                S_CLR:
                begin
                    clr_reg <= clr_reg + CW'(1);
                    if (clr_reg[AW-1:0] == AW'(dnsx_pkg::MsgDepth - 1))
                    begin
                        pos_reg <= cur_reg;
                        hops_reg <= '0;
                        wire_reg <= '0;
                        jumped_reg <= 1'b0;
                        state_reg <= S_NB_RD;
                    end
                end
                S_NB_RD:
                begin
                    if (pos_reg >= len)
                    begin
                        st_reg <= dnsx_pkg::ST_TRUNC;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        raddr_reg <= pos_reg[AW-1:0];
                        state_reg <= S_NB_WT;
                    end
                end
                S_NB_WT: state_reg <= S_NB_EVAL;
                S_NB_EVAL:
                begin
                    b_reg <= rd_data;
                    if ((rd_data & dnsx_pkg::PtrMask) == dnsx_pkg::PtrMask)
                    begin
                        if (remain < CW'(2))
                        begin
                            st_reg <= dnsx_pkg::ST_TRUNC;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            raddr_reg <= pos_reg[AW-1:0] + AW'(1);
                            state_reg <= S_P2_WT;
                        end
                    end
                    else if ((rd_data & dnsx_pkg::PtrMask) != '0)
                    begin
                        st_reg <= dnsx_pkg::ST_MAL;
                        state_reg <= S_DONE;
                    end
                    else if (rd_data == '0)
                    begin
                        if (!jumped_reg) next_reg <= pos_reg + CW'(1);
                        state_reg <= S_FIX;
                    end
                    else if (CW'(rd_data) > remain - CW'(1))
                    begin
                        st_reg <= dnsx_pkg::ST_TRUNC;
                        state_reg <= S_DONE;
                    end
                    else if (wire_reg + 9'(rd_data) + 9'd1 > dnsx_pkg::MaxWire)
                    begin
                        st_reg <= dnsx_pkg::ST_MAL;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        wire_reg <= wire_reg + 9'(rd_data) + 9'd1;
                        pos_reg <= pos_reg + CW'(rd_data) + CW'(1);
                        state_reg <= S_NB_RD;
                    end
                end
                S_P2_WT: state_reg <= S_P2_EVAL;
                S_P2_EVAL:
                begin
                    if (tgt_full >= 14'(len))
                    begin
                        st_reg <= dnsx_pkg::ST_MAL;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        if (!jumped_reg)
                        begin
                            next_reg <= pos_reg + CW'(2);
                            jumped_reg <= 1'b1;
                        end
                        tgt_reg <= tgt_full[AW-1:0];
                        state_reg <= S_V_WT;
                    end
                end
                S_V_WT: state_reg <= S_V_EVAL;
                S_V_EVAL:
                begin
                    if (v_rbit || hops_reg == dnsx_pkg::MaxHops)
                    begin
                        st_reg <= dnsx_pkg::ST_MAL;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        hops_reg <= hops_reg + 8'd1;
                        pos_reg <= CW'(tgt_reg);
                        state_reg <= S_NB_RD;
                    end
                end
                S_FIX:
                begin
                    if (!in_answer_reg)
                    begin
                        if (next_reg > len || len - next_reg < CW'(4))
                        begin
                            st_reg <= dnsx_pkg::ST_TRUNC;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            cur_reg <= next_reg + CW'(4);
                            state_reg <= S_SEC;
                        end
                    end
                    else if (next_reg > len || len - next_reg < dnsx_pkg::RrFixed)
                    begin
                        st_reg <= dnsx_pkg::ST_TRUNC;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        fx_idx_reg <= '0;
                        pos_reg <= next_reg;
                        state_reg <= S_FX_RD;
                    end
                end
                S_FX_RD:
                begin
                    raddr_reg <= pos_reg[AW-1:0] + AW'(fx_idx_reg);
                    state_reg <= S_FX_WT;
                end
                S_FX_WT: state_reg <= S_FX_EVAL;
                S_FX_EVAL:
                begin
                    acc_reg <= {acc_reg[23:0], rd_data};
                    fx_idx_reg <= fx_idx_reg + 4'd1;
                    if (fx_idx_reg == 4'd3) type_cls_reg <= {acc_reg[23:0], rd_data};
                    if (fx_idx_reg == 4'd7) ttl_reg <= {acc_reg[23:0], rd_data};
                    if (fx_idx_reg == 4'd9)
                    begin
                        dlen_reg <= {acc_reg[7:0], rd_data};
                        state_reg <= S_FX_AFTER;
                    end
                    else if (fx_idx_reg == 4'd13)
                    begin
                        addr_reg <= {acc_reg[23:0], rd_data};
                        ttlo_reg <= ttl_reg;
                        st_reg <= dnsx_pkg::ST_OK;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_FX_RD;
                    end
                end
                S_FX_AFTER:
                begin
                    if ({1'b0, dlen_reg} > 17'(len - pos_reg - dnsx_pkg::RrFixed))
                    begin
                        st_reg <= dnsx_pkg::ST_TRUNC;
                        state_reg <= S_DONE;
                    end
                    else if (type_cls_reg == 32'h0001_0001 && dlen_reg == 16'd4)
                    begin
                        state_reg <= S_FX_RD;
                    end
                    else
                    begin
                        cur_reg <= pos_reg + dnsx_pkg::RrFixed + CW'(dlen_reg);
                        state_reg <= S_SEC;
                    end
                end
                S_DONE:
                begin
                    if (st_reg != dnsx_pkg::ST_OK)
                    begin
                        addr_reg <= '0;
                        ttlo_reg <= '0;
                    end
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### src/dnsx_checker.sv
`default_nettype none
module dnsx_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic in_ready,
    input  wire logic last_byte,
    input  wire logic out_valid,
    input  wire logic out_ready,
    input  wire logic [1:0] status,
    input  wire logic [31:0] address,
    input  wire logic [31:0] ttl
);
    // no new bytes once the last one is in
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_byte |=> !in_ready)
        else $error("byte taken during parse");
    // no result while bytes are still being taken
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && in_ready))
        else $error("result and input open together");
    // failed status carries zero payload
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != dnsx_pkg::ST_OK |-> address == '0 && ttl == '0)
        else $error("payload on failure");
    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result dropped");
endmodule

bind dns_first_a_record_extractor dnsx_checker u_checker (.*);
`default_nettype wire
